/* sv/assert_macros.svh */
// Assertion macros used by the engine's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/ntt_pkg.sv */
// Package with the types, codes and constants of the transform engine.
package ntt_pkg;

    localparam int MAX_LENGTH = 4096;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int HALF_W     = ADDR_W - 1;
    localparam int LOG_W      = 4;
    localparam logic [LOG_W-1:0] LOG_MAX = LOG_W'(ADDR_W);

    localparam int SLOT_W  = 12;
    localparam int WORD_W  = 64;
    localparam int MOD_W   = 63;
    localparam int PADDR_W = 5;

    // Command codes.
    typedef enum logic [1:0] {
        ACT_LOAD_COEF = 2'd0,
        ACT_LOAD_TWID = 2'd1,
        ACT_RUN       = 2'd2,
        ACT_READ      = 2'd3
    } action_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_QINV    = 2'd1;
    localparam logic [1:0] REG_MODE    = 2'd2;
    localparam logic [1:0] REG_LOGLEN  = 2'd3;

    // Reduction modes.
    localparam logic MODE_BARRETT    = 1'b0;
    localparam logic MODE_MONTGOMERY = 1'b1;

    typedef struct packed {
        action_t             action;
        logic [SLOT_W-1:0]   slot;
        logic [WORD_W-1:0]   word;
        logic [WORD_W-1:0]   barrett_factor;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] read_slot;
        logic [MOD_W-1:0]  read_value;
    } rsp_t;

    // Operands of one modular product.
    typedef struct packed {
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] q;
        logic [WORD_W-1:0] qinv;
        logic              mode;
    } prod_req_t;

endpackage

/* sv/ntt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module ntt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/ntt_mul.sv */
// Multi-cycle 64 x 64 bit multiplier built on one 32 x 32 bit partial product.
module ntt_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] p
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [63:0]  pp_next;
    logic [1:0]   sh_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [127:0] acc_reg;
    logic [127:0] pp_ext;
    logic [31:0]  a_half;
    logic [31:0]  b_half;

    // Partial product select: the count walks the four half-word pairs.
    assign a_half  = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half  = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp_next = 64'(a_half) * 64'(b_half);
    assign pp_ext  = {64'd0, pp_reg} << {sh_reg, 5'd0};

    // Control: the count walks the four partial products; accumulation trails them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                pp_reg <= pp_next;
                sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_ext;
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

/* sv/ntt_mulmod.sv */
// Modular product unit: Barrett or Montgomery reduction over three wide multiplies.
module ntt_mulmod (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ntt_pkg::prod_req_t req,
    output logic              done,
    output logic [63:0]       v
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_A,
        M_B,
        M_C
    } mstate_t;

    mstate_t            state_reg;
    ntt_pkg::prod_req_t req_reg;
    logic [127:0]       u_reg;
    logic [63:0]        ma_reg;
    logic [63:0]        mb_reg;
    logic [63:0]        v_reg;
    logic [63:0]        v_next;
    logic               mstart_reg;
    logic               done_reg;
    logic               mdone;
    logic [127:0]       mp;
    logic [63:0]        z;
    logic [63:0]        u1;
    logic [63:0]        h;

    ntt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart_reg),
        .a     (ma_reg),
        .b     (mb_reg),
        .done  (mdone),
        .p     (mp)
    );

    // Final reduction once the third product is ready.
    assign z  = u_reg[63:0] - mp[63:0];
    assign u1 = u_reg[127:64];
    assign h  = mp[127:64];
    always_comb
    begin
        if (req_reg.mode == ntt_pkg::MODE_MONTGOMERY)
        begin
            v_next = (u1 < h) ? (u1 + req_reg.q - h) : (u1 - h);
        end
        else
        begin
            v_next = (z >= req_reg.q) ? (z - req_reg.q) : z;
        end
    end

    // Sequencer over the three multiplies.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            mstart_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            mstart_reg <= 1'b0;
            done_reg   <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        mstart_reg <= 1'b1;
                        state_reg  <= M_A;
                    end
                end
                M_A:
                begin
                    if (mdone)
                    begin
                        mstart_reg <= 1'b1;
                        state_reg  <= M_B;
                    end
                end
                M_B:
                begin
                    if (mdone)
                    begin
                        mstart_reg <= 1'b1;
                        state_reg  <= M_C;
                    end
                end
                M_C:
                begin
                    if (mdone)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    // Operand registers for the multiplier.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    req_reg <= req;
                    ma_reg  <= req.t;
                    mb_reg  <= req.w;
                end
            end
            M_A:
            begin
                if (mdone)
                begin
                    u_reg <= mp;
                    if (req_reg.mode == ntt_pkg::MODE_MONTGOMERY)
                    begin
                        ma_reg <= mp[63:0];
                        mb_reg <= req_reg.qinv;
                    end
                    else
                    begin
                        ma_reg <= req_reg.t;
                        mb_reg <= req_reg.r;
                    end
                end
            end
            M_B:
            begin
                if (mdone)
                begin
                    if (req_reg.mode == ntt_pkg::MODE_MONTGOMERY)
                    begin
                        ma_reg <= mp[63:0];
                        mb_reg <= req_reg.q;
                    end
                    else
                    begin
                        ma_reg <= req_reg.q;
                        mb_reg <= mp[127:64];
                    end
                end
            end
            M_C:
            begin
                if (mdone)
                begin
                    v_reg <= v_next;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign v    = v_reg;

endmodule

/* sv/ntt_forward_modular_engine.sv */
// Top level of the forward number theoretic transform engine.
// Usage: a command transaction is taken when start is high and busy is low.
// Load coefficient and load twiddle write one memory entry and leave busy low;
// such commands may follow each other in every cycle.
// Read coefficient returns its result in the cycle after acceptance: done is high
// for exactly one cycle with the slot and the low 63 bits of the stored value.
// Reads also stream at one per cycle.
// Run transform holds busy high for N/2*log2(N) butterflies; each passes through
// two read states, a capture state, a wait in the multiply state for the product
// and the two write-backs on the single write port of the coefficient RAM.
// The product unit runs its three 64 x 64 products in turn through
// one shared 32 x 32 multiplier; it starts with the capture cycle.
// The configuration registers sit on the APB port at byte addresses 0, 8, 16
// and 24; they are to be written only while the engine is idle, unchecked.
// Reset clears the registers to their defaults and the control state; the
// memories hold no defined value until written. The receiver cannot stall.
`include "assert_macros.svh"

module ntt_forward_modular_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ntt_pkg::cmd_t                 cmd,
    output logic                          done,
    output ntt_pkg::rsp_t                 rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ntt_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HI,
        S_RD_LO,
        S_CAPX,
        S_MUL,
        S_WR_HI,
        S_WR_LO
    } state_t;

    localparam int AW = ntt_pkg::ADDR_W;
    localparam int HW = ntt_pkg::HALF_W;
    localparam int LW = ntt_pkg::LOG_W;

    state_t                        state_reg;
    logic [ntt_pkg::MOD_W-1:0]     modulus_reg;
    logic [63:0]                   qinv_reg;
    logic                          mode_reg;
    logic [LW-1:0]                 loglen_reg;
    logic                          rd_pend_reg;
    logic [ntt_pkg::SLOT_W-1:0]    rd_slot_reg;
    logic [LW-1:0]                 lg_reg;
    logic [LW-1:0]                 s_reg;
    logic [LW-1:0]                 lt_reg;
    logic [HW-1:0]                 k_reg;
    logic [63:0]                   x_reg;
    logic [63:0]                   hi_reg;
    logic [63:0]                   lo_reg;

    logic                          accept;
    logic                          cfg_wr;
    logic [LW-1:0]                 lg_eff;
    logic [AW-1:0]                 kx;
    logic [AW-1:0]                 lomask;
    logic [AW-1:0]                 kmask;
    logic [AW-1:0]                 j_idx;
    logic [AW-1:0]                 jt_idx;
    logic [AW-1:0]                 tw_idx;
    logic                          last_k;
    logic [63:0]                   q64;

    logic                          coef_we;
    logic [AW-1:0]                 coef_waddr;
    logic [63:0]                   coef_wdata;
    logic [AW-1:0]                 coef_raddr;
    logic [63:0]                   coef_rdata;
    logic                          tw_we;
    logic [127:0]                  tw_rdata;

    ntt_pkg::prod_req_t            preq;
    logic                          pstart;
    logic                          pdone;
    logic [63:0]                   pv;
    logic [63:0]                   bf_sum;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign q64    = {1'b0, modulus_reg};

    // Transform length saturates at the store size.
    assign lg_eff = (loglen_reg > ntt_pkg::LOG_MAX) ? ntt_pkg::LOG_MAX : loglen_reg;

    // Butterfly addressing: j is k with a zero inserted at bit lt.
    assign kx     = {1'b0, k_reg};
    assign lomask = (AW'(1) << lt_reg) - AW'(1);
    assign j_idx  = (((kx >> lt_reg) << 1) << lt_reg) | (kx & lomask);
    assign jt_idx = j_idx | (AW'(1) << lt_reg);
    assign tw_idx = (AW'(1) << s_reg) | (kx >> lt_reg);
    assign kmask  = (AW'(1) << (lg_reg - LW'(1))) - AW'(1);
    assign last_k = (kx == kmask);

    // Memory port selection.
    always_comb
    begin
        coef_we    = 1'b0;
        coef_waddr = cmd.slot[AW-1:0];
        coef_wdata = cmd.word;
        coef_raddr = cmd.slot[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                coef_we = accept && (cmd.action == ntt_pkg::ACT_LOAD_COEF);
            end
            S_RD_HI:
            begin
                coef_raddr = jt_idx;
            end
            S_RD_LO:
            begin
                coef_raddr = j_idx;
            end
            S_WR_HI:
            begin
                coef_we    = 1'b1;
                coef_waddr = jt_idx;
                coef_wdata = hi_reg;
            end
            S_WR_LO:
            begin
                coef_we    = 1'b1;
                coef_waddr = j_idx;
                coef_wdata = lo_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign tw_we = accept && (cmd.action == ntt_pkg::ACT_LOAD_TWID);

    ntt_ram #(
        .WIDTH (64),
        .DEPTH (ntt_pkg::MAX_LENGTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // Twiddle and Barrett factor share one entry.
    ntt_ram #(
        .WIDTH (128),
        .DEPTH (ntt_pkg::MAX_LENGTH)
    ) u_tw_ram (
        .clk   (clk),
        .we    (tw_we),
        .waddr (cmd.slot[AW-1:0]),
        .wdata ({cmd.barrett_factor, cmd.word}),
        .raddr (tw_idx),
        .rdata (tw_rdata)
    );

    // Product of the upper element with the group twiddle.
    assign pstart    = (state_reg == S_RD_LO);
    assign preq.t    = coef_rdata;
    assign preq.w    = tw_rdata[63:0];
    assign preq.r    = tw_rdata[127:64];
    assign preq.q    = q64;
    assign preq.qinv = qinv_reg;
    assign preq.mode = mode_reg;

    ntt_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pstart),
        .req   (preq),
        .done  (pdone),
        .v     (pv)
    );

    assign bf_sum = x_reg + pv;

    // Butterfly sequencer, read pipeline and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            modulus_reg <= ntt_pkg::MOD_W'(3);
            qinv_reg    <= '0;
            mode_reg    <= ntt_pkg::MODE_BARRETT;
            loglen_reg  <= LW'(12);
            lg_reg      <= '0;
            s_reg       <= '0;
            lt_reg      <= '0;
            k_reg       <= '0;
        end
        else
        begin
            rd_pend_reg <= accept && (cmd.action == ntt_pkg::ACT_READ);
            if (cfg_wr)
            begin
                case (paddr[4:3])
                    ntt_pkg::REG_MODULUS: modulus_reg <= pwdata[ntt_pkg::MOD_W-1:0];
                    ntt_pkg::REG_QINV:    qinv_reg    <= pwdata;
                    ntt_pkg::REG_MODE:    mode_reg    <= pwdata[0];
                    ntt_pkg::REG_LOGLEN:  loglen_reg  <= pwdata[LW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (cmd.action == ntt_pkg::ACT_RUN) && (lg_eff != '0))
                    begin
                        lg_reg    <= lg_eff;
                        s_reg     <= '0;
                        lt_reg    <= lg_eff - LW'(1);
                        k_reg     <= '0;
                        state_reg <= S_RD_HI;
                    end
                end
                S_RD_HI: state_reg <= S_RD_LO;
                S_RD_LO: state_reg <= S_CAPX;
                S_CAPX:  state_reg <= S_MUL;
                S_MUL:
                begin
                    if (pdone)
                    begin
                        state_reg <= S_WR_HI;
                    end
                end
                S_WR_HI: state_reg <= S_WR_LO;
                S_WR_LO:
                begin
                    if (last_k)
                    begin
                        k_reg <= '0;
                        if (lt_reg == '0)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            s_reg     <= s_reg + LW'(1);
                            lt_reg    <= lt_reg - LW'(1);
                            state_reg <= S_RD_HI;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + HW'(1);
                        state_reg <= S_RD_HI;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Butterfly data registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_slot_reg <= cmd.slot;
        end
        if (state_reg == S_CAPX)
        begin
            x_reg <= coef_rdata;
        end
        if ((state_reg == S_MUL) && pdone)
        begin
            hi_reg <= (x_reg < pv) ? (x_reg + q64 - pv) : (x_reg - pv);
            lo_reg <= (bf_sum >= q64) ? (bf_sum - q64) : bf_sum;
        end
    end

    // Read-back of the configuration registers.
    always_comb
    begin
        case (paddr[4:3])
            ntt_pkg::REG_MODULUS: prdata = q64;
            ntt_pkg::REG_QINV:    prdata = qinv_reg;
            ntt_pkg::REG_MODE:    prdata = {63'd0, mode_reg};
            ntt_pkg::REG_LOGLEN:  prdata = {60'd0, loglen_reg};
            default:              prdata = '0;
        endcase
    end

    assign done           = rd_pend_reg;
    assign rsp.read_slot  = rd_slot_reg;
    assign rsp.read_value = coef_rdata[ntt_pkg::MOD_W-1:0];

    // A result follows only a read transaction accepted in the previous cycle.
    `ASSERT_IMPLY(a_done_after_read, clk, rst_n, done,
        $past(start && !busy && (cmd.action == ntt_pkg::ACT_READ)),
        "result without a read transaction")
    // The product unit completes only while the sequencer waits for it.
    `ASSERT_IMPLY(a_prod_in_mul, clk, rst_n, pdone, state_reg == S_MUL,
        "product completed outside the multiply state")
    // During a run the coefficient RAM is written only in write-back states.
    `ASSERT_IMPLY(a_run_writes, clk, rst_n, coef_we && (state_reg != S_IDLE),
        (state_reg == S_WR_HI) || (state_reg == S_WR_LO),
        "coefficient write outside write-back")

endmodule
